>>> rtl/qoienc_pkg.sv
`timescale 1ns / 1ps

package qoienc_pkg;

   // Chunk opcodes, QOI format
   localparam logic [1:0] OP_INDEX = 2'b00;
   localparam logic [1:0] OP_DIFF  = 2'b01;
   localparam logic [1:0] OP_LUMA  = 2'b10;
   localparam logic [1:0] OP_RUN   = 2'b11;
   localparam logic [7:0] OP_RGB   = 8'hFE;
   localparam logic [7:0] OP_RGBA  = 8'hFF;

   localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
   localparam logic [31:0] PIXEL_RESET  = 32'hFF00_0000;
   localparam int          RUN_LIMIT    = 62;
   localparam int          PAD_LEN      = 8;
   localparam logic [7:0]  PAD_FINAL    = 8'h01;
   localparam int          MAX_BYTES    = 6;

   // Configuration register indexes (byte address / 4)
   localparam logic REG_ALPHA_ON = 1'b0;

   // Bytes one pixel produces before padding: optional run chunk plus up to
   // five bytes of index, diff, luma, RGB or RGBA chunk.
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] data;
      logic [2:0]                count;
      logic                      last;
   } rec_type;

endpackage

>>> rtl/qoienc_ram.sv
`timescale 1ns / 1ps

module qoienc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/qoienc_chunk.sv
`timescale 1ns / 1ps

module qoienc_chunk #(
   parameter int HASH_W = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [31:0]           pix,
   input  logic                  last,
   input  logic [HASH_W-1:0]     hash,
   input  logic [31:0]           entry,
   output qoienc_pkg::rec_type   rec,
   output logic                  push,
   output logic                  miss
);

   logic [31:0] prev_ff, prev_in;
   logic [5:0]  run_ff, run_in;

   logic        same;
   logic [7:0]  dr, dg, db;
   logic [8:0]  drg8, dbg8;
   logic        run_emit;
   logic [7:0]  run_byte;
   logic [4:0][7:0] cb;
   logic [2:0]  clen;

   always_comb begin
      same = (pix == prev_ff);
      dr   = pix[7:0]   - prev_ff[7:0];
      dg   = pix[15:8]  - prev_ff[15:8];
      db   = pix[23:16] - prev_ff[23:16];
      drg8 = {dr[7], dr} - {dg[7], dg} + 9'd8;
      dbg8 = {db[7], db} - {dg[7], dg} + 9'd8;

      run_emit = 1'b0;
      run_byte = {qoienc_pkg::OP_RUN, run_ff};
      cb       = '0;
      clen     = 3'd0;
      miss     = 1'b0;
      run_in   = run_ff;

      if (same) begin
         if (run_ff >= 6'(qoienc_pkg::RUN_LIMIT - 1) || last) begin
            // count reaches the limit or the final pixel arrives: flush, byte holds count minus one
            run_emit = 1'b1;
            run_in   = 6'd0;
         end else begin
            run_in = run_ff + 6'd1;
         end
      end else begin
         run_in = 6'd0;
         if (run_ff != 6'd0) begin
            run_emit = 1'b1;
            run_byte = {qoienc_pkg::OP_RUN, run_ff - 6'd1};
         end
         if (entry == pix) begin
            cb[0] = {qoienc_pkg::OP_INDEX, 6'(hash)};
            clen  = 3'd1;
         end else begin
            miss = 1'b1;
            if (pix[31:24] == prev_ff[31:24]) begin
               if ((dr + 8'd2) < 8'd4 && (dg + 8'd2) < 8'd4 && (db + 8'd2) < 8'd4) begin
                  cb[0] = {qoienc_pkg::OP_DIFF, 2'(dr + 8'd2), 2'(dg + 8'd2),
                           2'(db + 8'd2)};
                  clen  = 3'd1;
               end else if ((dg + 8'd32) < 8'd64 && drg8 < 9'd16 && dbg8 < 9'd16) begin
                  cb[0] = {qoienc_pkg::OP_LUMA, 6'(dg + 8'd32)};
                  cb[1] = {drg8[3:0], dbg8[3:0]};
                  clen  = 3'd2;
               end else begin
                  cb[0] = qoienc_pkg::OP_RGB;
                  cb[1] = pix[7:0];
                  cb[2] = pix[15:8];
                  cb[3] = pix[23:16];
                  clen  = 3'd4;
               end
            end else begin
               cb[0] = qoienc_pkg::OP_RGBA;
               cb[1] = pix[7:0];
               cb[2] = pix[15:8];
               cb[3] = pix[23:16];
               cb[4] = pix[31:24];
               clen  = 3'd5;
            end
         end
      end

      if (last) begin
         run_in = 6'd0;
      end
      prev_in = last ? qoienc_pkg::PIXEL_RESET : pix;
   end

   // Place run chunk first, shift the pixel chunk behind it
   always_comb begin
      rec.data = '0;
      if (run_emit) begin
         rec.data[0] = run_byte;
         for (int i = 1; i < qoienc_pkg::MAX_BYTES; i++) begin
            rec.data[i] = cb[i-1];
         end
      end else begin
         for (int i = 0; i < qoienc_pkg::MAX_BYTES - 1; i++) begin
            rec.data[i] = cb[i];
         end
      end
      rec.count = clen + {2'b00, run_emit};
      rec.last  = last;
      push      = (rec.count != 3'd0) || last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= qoienc_pkg::PIXEL_RESET;
         run_ff  <= 6'd0;
      end else if (advance) begin
         prev_ff <= prev_in;
         run_ff  <= run_in;
      end
   end

endmodule

>>> rtl/qoienc_serializer.sv
`timescale 1ns / 1ps

module qoienc_serializer (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  qoienc_pkg::rec_type rec,
   output logic                ready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast,
   output logic                rsp_tuser
);

   qoienc_pkg::rec_type cur_ff;
   logic                valid_ff;
   logic [3:0]          idx_ff;

   logic [3:0] total;
   logic       at_end;
   logic       fire;

   always_comb begin
      total  = {1'b0, cur_ff.count} + (cur_ff.last ? 4'(qoienc_pkg::PAD_LEN) : 4'd0);
      at_end = (idx_ff == total - 4'd1);
      fire   = valid_ff && rsp_tready;
      ready  = !valid_ff || (fire && at_end);

      if (idx_ff < {1'b0, cur_ff.count}) begin
         rsp_tdata = cur_ff.data[idx_ff[2:0]];
      end else begin
         rsp_tdata = at_end ? qoienc_pkg::PAD_FINAL : 8'd0;
      end
      rsp_tvalid = valid_ff;
      rsp_tlast  = at_end;
      rsp_tuser  = at_end && cur_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 4'd0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= 4'd0;
      end else if (fire && at_end) begin
         valid_ff <= 1'b0;
      end else if (fire) begin
         idx_ff <= idx_ff + 4'd1;
      end
   end

   // advance the record without reset
   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= rec;
      end
   end

endmodule

>>> rtl/qoi_pixel_stream_encoder.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake          | Payload
// req      | in        | tvalid/tready      | tdata: red, green, blue, alpha; tlast: final pixel
// rsp      | out       | tvalid/tready      | tdata: code byte; tlast: item done; tuser: image done
// csr      | in        | APB psel/penable   | register 0: alpha_channel_on (bit 0)
//
// One pixel per cycle enters while every pixel yields at most one byte and rsp is
// not stalled; a pixel with bytes holds the single-byte output serializer until it
// has emitted all of them (1 to 14), and a pixel that only extends a run skips it.
// Index lookup: read at acceptance, compare in the cycle after; a write by the
// departing pixel to the entry that the next pixel reads is forwarded.
// Reset is synchronous; the index is empty at once (valid bits, no clearing pass).
// A stalled rsp holds the coder stage, which in turn drops req_tready.

module qoi_pixel_stream_encoder #(
   parameter int INDEX_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   // pixel transactions
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
   input  logic        req_tlast,
   // code byte transactions
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] code_byte
   output logic        rsp_tlast,
   output logic        rsp_tuser,   // [0] image_done
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int HASH_W = $clog2(INDEX_ENTRIES);

   // configuration register
   logic alpha_on_ff;

   // coder stage
   logic              s1_valid_ff;
   logic [31:0]       s1_pix_ff;
   logic              s1_last_ff;
   logic [HASH_W-1:0] s1_hash_ff;
   logic              fwd_ff;
   logic [31:0]       fwd_pix_ff;
   logic [INDEX_ENTRIES-1:0] valid_ff, valid_in;

   logic [7:0]        alpha_in;
   logic [31:0]       pix_in;
   logic [12:0]       hash_sum;
   logic [HASH_W-1:0] hash_in;
   logic              req_fire;
   logic              s1_adv;
   logic              s1_stall;
   logic [HASH_W-1:0] rd_addr;
   logic [31:0]       ram_q;
   logic [31:0]       entry;
   logic              tbl_we;

   qoienc_pkg::rec_type rec;
   logic                push;
   logic                miss;
   logic                ser_ready;

   // APB: write on access phase, pready tied high
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == qoienc_pkg::REG_ALPHA_ON) ? {31'd0, alpha_on_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_on_ff <= 1'b1;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == qoienc_pkg::REG_ALPHA_ON) begin
         alpha_on_ff <= csr_pwdata[0];
      end
   end

   // Pixel in: force alpha opaque in RGB mode, hash (3r + 5g + 7b + 11a) mod entries
   always_comb begin
      alpha_in = alpha_on_ff ? req_tdata[31:24] : qoienc_pkg::ALPHA_OPAQUE;
      pix_in   = {alpha_in, req_tdata[23:0]};
      hash_sum = {5'd0, req_tdata[7:0]} * 13'd3 + {5'd0, req_tdata[15:8]} * 13'd5
               + {5'd0, req_tdata[23:16]} * 13'd7 + {5'd0, alpha_in} * 13'd11;
      hash_in  = hash_sum[HASH_W-1:0];
   end

   assign s1_adv     = s1_valid_ff && (!push || ser_ready);
   assign s1_stall   = s1_valid_ff && !s1_adv;
   assign req_tready = !s1_stall;
   assign req_fire   = req_tvalid && req_tready;
   assign tbl_we     = s1_adv && miss;

   // Re-read the held entry while the coder stage waits
   assign rd_addr = s1_stall ? s1_hash_ff : hash_in;

   qoienc_ram #(
      .WIDTH (32),
      .DEPTH (INDEX_ENTRIES)
   ) u_index (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (s1_hash_ff),
      .wr_data (s1_pix_ff),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // Entry never written since the last clear reads as zero
   assign entry = valid_ff[s1_hash_ff] ? (fwd_ff ? fwd_pix_ff : ram_q) : 32'd0;

   always_comb begin
      valid_in = valid_ff;
      if (tbl_we) begin
         valid_in[s1_hash_ff] = 1'b1;
      end
      if (s1_adv && s1_last_ff) begin
         valid_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         valid_ff    <= '0;
      end else begin
         valid_ff <= valid_in;
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   // Capture the pixel; forward the entry the departing pixel writes this cycle
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pix_ff  <= pix_in;
         s1_last_ff <= req_tlast;
         s1_hash_ff <= hash_in;
         fwd_ff     <= tbl_we && (s1_hash_ff == hash_in);
         fwd_pix_ff <= s1_pix_ff;
      end
   end

   qoienc_chunk #(
      .HASH_W (HASH_W)
   ) u_chunk (
      .clock   (clock),
      .reset   (reset),
      .advance (s1_adv),
      .pix     (s1_pix_ff),
      .last    (s1_last_ff),
      .hash    (s1_hash_ff),
      .entry   (entry),
      .rec     (rec),
      .push    (push),
      .miss    (miss)
   );

   qoienc_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load       (s1_adv && push),
      .rec        (rec),
      .ready      (ser_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // image done only ever marks the last byte of a pixel
   assert property (@(posedge clock) disable iff (reset) rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("image_done without item_done");

   // a waiting pixel keeps its data
   assert property (@(posedge clock) disable iff (reset)
                    s1_stall |=> s1_valid_ff && $stable(s1_pix_ff) && $stable(s1_hash_ff))
      else $error("coder stage lost a stalled pixel");

   // the index is empty after the final pixel leaves
   assert property (@(posedge clock) disable iff (reset)
                    s1_adv && s1_last_ff |=> valid_ff == '0)
      else $error("index not cleared after final pixel");

   // an empty coder stage never holds off the sender
   assert property (@(posedge clock) disable iff (reset)
                    !s1_valid_ff |-> req_tready)
      else $error("req_tready low with empty coder stage");

endmodule
